>>> hw/rtl/dcc_pkg.sv
// Package for the distinct color collector: field widths and the
// command and status structs passed between controller and datapath.
// No dependencies.
`default_nettype none

package dcc_pkg;

    // Widths of the request and result fields.
    localparam int COLOR_W = 31;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a new request
        logic scan;     // advance the table search by one entry
        logic finish;   // commit the outcome into the result register
    } dcc_cmd_t;

    // Search status from the datapath to the controller.
    typedef struct packed {
        logic hit;      // the compared entry matches the pixel
        logic miss;     // every stored entry was compared without a match
    } dcc_status_t;

endpackage : dcc_pkg

`default_nettype wire

>>> hw/rtl/dcc_ifs.sv
// Valid/ready channel interfaces for the pixel requests and the results
// of the distinct color collector. Depends on dcc_pkg.
`default_nettype none

interface dcc_pixel_if;
    import dcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color;
    logic               start_req;

    modport source (output valid, output color, output start_req, input ready);
    modport sink   (input valid, input color, input start_req, output ready);
endinterface : dcc_pixel_if

interface dcc_result_if;
    import dcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] entry_index;
    logic               is_new;
    logic [COUNT_W-1:0] color_count;
    logic               overflow;

    modport source (output valid, output entry_index, output is_new,
                    output color_count, output overflow, input ready);
    modport sink   (input valid, input entry_index, input is_new,
                    input color_count, input overflow, output ready);
endinterface : dcc_result_if

`default_nettype wire

>>> hw/rtl/dcc_ctrl.sv
// Controller of the distinct color collector: sequences request capture,
// table search and result commit, and owns the result valid flag.
// Depends on dcc_pkg.
`default_nettype none

module dcc_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire                 out_ready,
    input  dcc_pkg::dcc_status_t status,
    output dcc_pkg::dcc_cmd_t    cmd
);
    import dcc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   done;
    logic   out_free;

    // Search is over once a match or the end of the table is seen; the
    // outcome may be committed when the result register is free or draining.
    assign done     = status.hit | status.miss;
    assign out_free = ~out_valid_reg | out_ready;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Command decode.
    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) & in_valid;
        cmd.scan   = (state_reg == ST_SCAN) & ~done;
        cmd.finish = (state_reg == ST_SCAN) & done & out_free;
    end

    // Next state and next result valid.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (done && out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : dcc_ctrl

`default_nettype wire

>>> hw/rtl/dcc_datapath.sv
// Datapath of the distinct color collector: the color table memory, the
// stored-color count, the pipelined search compare and the result register.
// Depends on dcc_pkg.
`default_nettype none

module dcc_datapath #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  dcc_pkg::dcc_cmd_t            cmd,
    output dcc_pkg::dcc_status_t         status,
    input  wire [dcc_pkg::COLOR_W-1:0]   color,
    input  wire                          start_req,
    output logic [dcc_pkg::INDEX_W-1:0]  entry_index,
    output logic                         is_new,
    output logic [dcc_pkg::COUNT_W-1:0]  color_count,
    output logic                         overflow
);
    import dcc_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

    // Color table; entries at or above the count are never read.
    logic [COLOR_W-1:0] table_mem [PALETTE_DEPTH];

    logic [COLOR_W-1:0] pixel_reg;
    logic [COLOR_W-1:0] rdata_reg;
    logic [AW-1:0]      cmp_idx_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      raddr_reg;
    logic [CW-1:0]      raddr_next;
    logic               pend_reg;
    logic               pend_next;
    logic [AW-1:0]      res_idx_reg;
    logic [CW-1:0]      res_count_reg;
    logic               res_new_reg;
    logic               res_ovf_reg;

    logic               issue;
    logic               full;
    logic               store;
    logic [AW+INDEX_W-1:0] idx_ext;
    logic [CW+COUNT_W-1:0] count_ext;

    // Search status: one entry read is in flight at a time behind the issue.
    assign issue       = raddr_reg < count_reg;
    assign full        = count_reg == DEPTH_C;
    assign status.hit  = pend_reg & (rdata_reg == pixel_reg);
    assign status.miss = ~pend_reg & ~issue;
    assign store       = cmd.finish & status.miss & ~full;

    // Next values of the search pointer, the in-flight flag and the count.
    always_comb
    begin
        raddr_next = raddr_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            raddr_next = '0;
            pend_next  = 1'b0;
            if (start_req)
            begin
                count_next = '0;
            end
        end
        else if (cmd.scan)
        begin
            pend_next = issue;
            if (issue)
            begin
                raddr_next = raddr_reg + CW'(1);
            end
        end
        if (store)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            raddr_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            raddr_reg <= raddr_next;
            pend_reg  <= pend_next;
        end
    end

    // Table memory: one write port for appends, one registered read port.
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            table_mem[count_reg[AW-1:0]] <= pixel_reg;
        end
        if (cmd.scan && issue)
        begin
            rdata_reg   <= table_mem[raddr_reg[AW-1:0]];
            cmp_idx_reg <= raddr_reg[AW-1:0];
        end
    end

    // Request capture and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pixel_reg <= color;
        end
        if (cmd.finish)
        begin
            res_count_reg <= count_next;
            res_new_reg   <= status.miss;
            res_ovf_reg   <= status.miss & full;
            if (status.hit)
            begin
                res_idx_reg <= cmp_idx_reg;
            end
            else if (full)
            begin
                res_idx_reg <= '0;
            end
            else
            begin
                res_idx_reg <= count_reg[AW-1:0];
            end
        end
    end

    // Fit the result to the field widths: zero-extend or keep the low bits.
    assign idx_ext     = {{INDEX_W{1'b0}}, res_idx_reg};
    assign count_ext   = {{COUNT_W{1'b0}}, res_count_reg};
    assign entry_index = idx_ext[INDEX_W-1:0];
    assign color_count = count_ext[COUNT_W-1:0];
    assign is_new      = res_new_reg;
    assign overflow    = res_ovf_reg;

endmodule : dcc_datapath

`default_nettype wire

>>> hw/rtl/distinct_color_collector_core.sv
// Top level of the distinct color collector: controller plus datapath.
// Depends on dcc_pkg, dcc_ifs, dcc_ctrl and dcc_datapath.
//
// Usage:
//   pixel  (sink)   requests carry a 31-bit color and start_req. start_req
//                   empties the table before the color is looked up.
//   result (source) one result per request: entry_index, is_new,
//                   color_count and overflow.
// Timing: a request is taken while the block is idle, then the stored
//   colors are read one per cycle from the table memory, whose read data
//   is registered. The search ends on a match or once every stored color
//   has been compared; the result is valid on the following cycle.
// The result register decouples the two sides: the next request is taken
//   while a result is still waiting. If the receiver stalls, a finished
//   search holds until the result register frees up.
// Reset clears the stored-color count and the handshake state; the table
//   contents are not cleared and need no clearing pass.
`default_nettype none

module distinct_color_collector_core #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire            clk,
    input  wire            rst_n,
    dcc_pixel_if.sink      pixel,
    dcc_result_if.source   result
);
    import dcc_pkg::*;

    dcc_cmd_t    cmd;
    dcc_status_t status;

    dcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dcc_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .color       (pixel.color),
        .start_req   (pixel.start_req),
        .entry_index (result.entry_index),
        .is_new      (result.is_new),
        .color_count (result.color_count),
        .overflow    (result.overflow)
    );

endmodule : distinct_color_collector_core

`default_nettype wire

>>> hw/rtl/dcc_checker.sv
// Port-level checks for the distinct color collector and the bind that
// attaches them to the top level. Depends on dcc_pkg and the top level.
`default_nettype none

module dcc_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire [dcc_pkg::INDEX_W-1:0]   entry_index,
    input wire                          is_new,
    input wire [dcc_pkg::COUNT_W-1:0]   color_count,
    input wire                          overflow
);
    import dcc_pkg::*;

    // A stalled result keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_index)
            && $stable(is_new) && $stable(color_count) && $stable(overflow))
        else $error("result changed while stalled");

    // A dropped color is always reported as new at position zero.
    a_overflow_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> is_new && (entry_index == '0))
        else $error("overflow result not new or not at position zero");

    // A newly stored color leaves a nonempty table.
    a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_new && !overflow |-> color_count != '0)
        else $error("new color stored but count is zero");

    // Results out of reset start with no pending result.
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule : dcc_checker

bind distinct_color_collector_core dcc_checker u_dcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .entry_index (result.entry_index),
    .is_new      (result.is_new),
    .color_count (result.color_count),
    .overflow    (result.overflow)
);

`default_nettype wire

>>> verif/distinct_color_collector_core_tb.sv
`timescale 1ns / 1ps
// Testbench for distinct_color_collector_core: sends pixel requests and checks
// every result against a built-in model of the distinct-color palette.
// Depends on dcc_pkg, the channel interfaces in dcc_ifs and the RTL of the core.

module distinct_color_collector_core_tb;
    import dcc_pkg::*;

    localparam int PALETTE_DEPTH = 256;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 400;

    // One result as the core reports it.
    typedef struct packed {
        logic [INDEX_W-1:0] entry_index;
        logic               is_new;
        logic [COUNT_W-1:0] color_count;
        logic               overflow;
    } color_lookup_t;

    logic clk = 1'b0;
    logic rst_n;

    dcc_pixel_if  pixel_ch ();
    dcc_result_if result_ch ();

    distinct_color_collector_core #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_ch.sink),
        .result (result_ch.source)
    );

    // Model state: the stored colors and how many of them are valid.
    bit [COLOR_W-1:0] palette_colors [PALETTE_DEPTH];
    int               palette_fill;

    color_lookup_t lookup_q [$];
    int            error_count;
    bit            tx_steady;
    bit            rx_steady;
    bit            rx_hold;
    event          hold_start;

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Look a pixel up in the model palette and update it as the core should.
    function automatic color_lookup_t lookup_color(input bit [COLOR_W-1:0] color,
                                                   input bit start_req);
        color_lookup_t res;
        int            pos;
        res = '0;
        if (start_req)
            palette_fill = 0;
        pos = 0;
        while (pos < palette_fill && palette_colors[pos] != color)
            pos++;
        if (pos == palette_fill)
        begin
            res.is_new = 1'b1;
            if (palette_fill < PALETTE_DEPTH)
            begin
                palette_colors[palette_fill] = color;
                palette_fill++;
            end
            else
            begin
                res.overflow = 1'b1;
                pos = 0;
            end
        end
        res.entry_index = pos[INDEX_W-1:0];
        res.color_count = palette_fill[COUNT_W-1:0];
        return res;
    endfunction

    // Offer one pixel request, with an optional idle gap first, and record
    // the expected result once it is accepted. Valid stays high on return.
    task automatic send_pixel(input bit [COLOR_W-1:0] color, input bit start_req);
        int gap;
        gap = 0;
        if (!tx_steady && $urandom_range(99) < 37)
            gap = ($urandom_range(9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid     <= 1'b1;
        pixel_ch.color     <= color;
        pixel_ch.start_req <= start_req;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        lookup_q.push_back(lookup_color(color, start_req));
    endtask

    // Pick a pixel: repeats of stored colors, near misses that differ
    // in one bit, corner values, or fresh random colors.
    function automatic bit [COLOR_W-1:0] pick_color(input int reuse_pct);
        bit [COLOR_W-1:0] c;
        int               r;
        r = $urandom_range(99);
        c = COLOR_W'($urandom);
        if (palette_fill > 0 && r < reuse_pct)
            c = palette_colors[$urandom_range(palette_fill - 1)];
        else if (palette_fill > 0 && r < reuse_pct + 10)
            c = palette_colors[$urandom_range(palette_fill - 1)]
                ^ (31'h1 << $urandom_range(COLOR_W - 1));
        else if (r < reuse_pct + 16)
        begin
            case ($urandom_range(5))
                0: c = '0;
                1: c = '1;
                2: c = 31'h0000_0001;
                3: c = 31'h4000_0000;
                4: c = 31'h2AAA_AAAA;
                default: c = 31'h5555_5555;
            endcase
        end
        return c;
    endfunction

    // Receiver: check each accepted result, then choose the next ready.
    initial
    begin
        color_lookup_t got;
        color_lookup_t want;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.entry_index = result_ch.entry_index;
                got.is_new      = result_ch.is_new;
                got.color_count = result_ch.color_count;
                got.overflow    = result_ch.overflow;
                if (lookup_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected result idx=%0d new=%0b cnt=%0d ovf=%0b",
                                 $realtime, got.entry_index, got.is_new,
                                 got.color_count, got.overflow);
                end
                else
                begin
                    want = lookup_q.pop_front();
                    if (got.entry_index !== want.entry_index || got.is_new !== want.is_new
                        || got.color_count !== want.color_count
                        || got.overflow !== want.overflow)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"%0t: mismatch expected idx=%0d new=%0b cnt=%0d ",
                                      "ovf=%0b, got idx=%0d new=%0b cnt=%0d ovf=%0b"},
                                     $realtime, want.entry_index, want.is_new,
                                     want.color_count, want.overflow, got.entry_index,
                                     got.is_new, got.color_count, got.overflow);
                    end
                end
            end
            if (rx_hold)
                result_ch.ready <= 1'b0;
            else if (rx_steady)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= 37);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps going meanwhile.
    initial
    begin
        rx_hold <= 1'b0;
        forever
        begin
            @(hold_start);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // Corner colors, hits, repeats and start requests on fresh and used tables.
    task automatic test_directed();
        send_pixel(31'h0000_0000, 1'b1);
        send_pixel(31'h0000_0000, 1'b0);
        send_pixel(31'h7FFF_FFFF, 1'b0);
        send_pixel(31'h7FFF_FFFF, 1'b0);
        send_pixel(31'h2AAA_AAAA, 1'b0);
        send_pixel(31'h5555_5555, 1'b0);
        send_pixel(31'h0000_0001, 1'b0);
        send_pixel(31'h4000_0000, 1'b0);
        send_pixel(31'h0000_0000, 1'b0);
        send_pixel(31'h5555_5555, 1'b0);
        send_pixel(31'h7FFF_FFFE, 1'b0);
        send_pixel(31'h00FF_FFFF, 1'b0);
        send_pixel(31'h7F00_0000, 1'b0);
        // A start request with a color that is already stored still lands at 0.
        send_pixel(31'h5555_5555, 1'b1);
        send_pixel(31'h7FFF_FFFF, 1'b0);
        send_pixel(31'h5555_5555, 1'b0);
        send_pixel(31'h7FFF_FFFF, 1'b1);
        send_pixel(31'h7FFF_FFFF, 1'b1);
        send_pixel(31'h0000_0000, 1'b0);
    endtask

    // Fill the table completely, then drive new and stored colors into the full table.
    task automatic test_table_full();
        for (int i = 0; i < PALETTE_DEPTH; i++)
            send_pixel(COLOR_W'(31'h1000_0000 | (i * 31'h0001_0203)), i == 0);
        send_pixel(31'h7FFF_FFFF, 1'b0);
        send_pixel(COLOR_W'(31'h1000_0000 | ((PALETTE_DEPTH - 1) * 31'h0001_0203)), 1'b0);
        send_pixel(31'h1000_0000, 1'b0);
        send_pixel(31'h0000_0000, 1'b0);
        send_pixel(COLOR_W'(31'h1000_0000 | (17 * 31'h0001_0203)), 1'b0);
        send_pixel(31'h0000_0000, 1'b1);
    endtask

    // Random runs, each opened by a start request. Most runs are short;
    // a few add mostly new colors so that the table fills and overflows.
    task automatic test_random_runs(input int n_items);
        int sent;
        int run_len;
        int reuse_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(24) == 0)
            begin
                run_len   = $urandom_range(270, 300);
                reuse_pct = 5;
            end
            else
            begin
                run_len   = $urandom_range(1, 40);
                reuse_pct = 45;
            end
            for (int i = 0; i < run_len && sent < n_items; i++)
            begin
                // Stray start requests in the middle of a run break it up.
                send_pixel(pick_color(reuse_pct), i == 0 || $urandom_range(49) == 0);
                sent++;
            end
        end
    endtask

    // Hold off the receiver while requests keep coming, so the core backs up.
    task automatic test_backpressure();
        tx_steady = 1'b1;
        -> hold_start;
        send_pixel(pick_color(50), 1'b1);
        for (int i = 0; i < 19; i++)
            send_pixel(pick_color(50), 1'b0);
        tx_steady = 1'b0;
    endtask

    // A stretch with no idling on either side.
    task automatic test_no_idle(input int n_items);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_pixel(pick_color(50), 1'b1);
        for (int i = 1; i < n_items; i++)
            send_pixel(pick_color(50), $urandom_range(29) == 0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        error_count  = 0;
        palette_fill = 0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        rst_n              <= 1'b0;
        pixel_ch.valid     <= 1'b0;
        pixel_ch.color     <= '0;
        pixel_ch.start_req <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_random_runs(880);
        test_backpressure();
        test_no_idle(150);
        test_random_runs(40);

        pixel_ch.valid <= 1'b0;
        wait (lookup_q.size() == 0);
        // Leave room for any stray result the core might still produce.
        repeat (PALETTE_DEPTH + 8) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule : distinct_color_collector_core_tb
